// ===== rtl/mtep_pkg.sv =====
// Types, codes and the status classifier for the MIDI track event parser.
// No dependencies; the files that use it refer to it by scoped names.
package mtep_pkg;

  localparam logic [7:0] DataMask   = 8'h7f;
  localparam logic [7:0] SysStatus  = 8'hf0;
  localparam logic [7:0] SysexStart = 8'hf0;
  localparam logic [7:0] SysexEsc   = 8'hf7;
  localparam logic [7:0] SongPos    = 8'hf2;
  localparam logic [7:0] SongSelect = 8'hf3;
  localparam logic [7:0] TuneReq    = 8'hf6;
  localparam logic [7:0] MetaStatus = 8'hff;
  localparam logic [7:0] MetaEot    = 8'h2f;

  typedef enum logic [2:0] {
    KIND_CHANNEL   = 3'd0,
    KIND_COMMON    = 3'd1,
    KIND_SYSEX     = 3'd2,
    KIND_ESC_SYSEX = 3'd3,
    KIND_META      = 3'd4,
    KIND_EMPTY     = 3'd5,
    KIND_UNKNOWN   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_DELTA    = 3'd0,
    PH_STATUS   = 3'd1,
    PH_DATA1    = 3'd2,
    PH_DATA2    = 3'd3,
    PH_DATAONE  = 3'd4,
    PH_METATYPE = 3'd5,
    PH_LENGTH   = 3'd6,
    PH_PAYLOAD  = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    CLS_TWO     = 3'd0,
    CLS_ONE     = 3'd1,
    CLS_SYSEX   = 3'd2,
    CLS_META    = 3'd3,
    CLS_TUNE    = 3'd4,
    CLS_UNKNOWN = 3'd5
  } cls_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [7:0]  meta_type;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_event;
    logic        end_of_track;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       track_start;
    cls_e       cls;
  } cmd_t;

  function automatic cls_e status_class(logic [7:0] s);
    cls_e c;
    c = CLS_UNKNOWN;
    if (s[7]) begin
      unique case (s[6:4])
        3'b000, 3'b001, 3'b010, 3'b011, 3'b110: c = CLS_TWO;
        3'b100, 3'b101:                          c = CLS_ONE;
        default: begin
          if (s == SongPos) begin
            c = CLS_TWO;
          end else if (s == SongSelect) begin
            c = CLS_ONE;
          end else if (s == SysexStart || s == SysexEsc) begin
            c = CLS_SYSEX;
          end else if (s == MetaStatus) begin
            c = CLS_META;
          end else if (s == TuneReq) begin
            c = CLS_TUNE;
          end else begin
            c = CLS_UNKNOWN;
          end
        end
      endcase
    end
    return c;
  endfunction

endpackage

// ===== rtl/mtep_fifo.sv =====
// Small register queue, used between front and back and for results.
// Depends on nothing; the item type comes in as a parameter.
module mtep_fifo #(
  parameter int unsigned Depth = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/mtep_front.sv =====
// Front end: takes track bytes and tags each with its status class.
// Depends on mtep_pkg.
module mtep_front (
  input  logic              valid_i,
  input  mtep_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              cmd_valid_o,
  output mtep_pkg::cmd_t    cmd_o,
  input  logic              cmd_full_i
);

  assign full_o              = cmd_full_i;
  assign cmd_valid_o         = valid_i;
  assign cmd_o.data          = item_i.in_byte;
  assign cmd_o.track_start   = item_i.track_start;
  assign cmd_o.cls           = mtep_pkg::status_class(item_i.in_byte);

endmodule

// ===== rtl/mtep_back.sv =====
// Back end: parse state machine; consumes tagged bytes, builds result items.
// Depends on mtep_pkg.
module mtep_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  mtep_pkg::cmd_t     cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output mtep_pkg::out_item_t res_o
);

  mtep_pkg::phase_e phase_q, phase_d, ph;
  mtep_pkg::cls_e   cls_q, cls_d, cl, eff_cl;
  logic [31:0] delta_q, delta_d, dacc;
  logic [7:0]  status_q, status_d, st, eff_st;
  logic [7:0]  held_q, held_d, held;
  logic [7:0]  meta_q, meta_d, meta;
  logic [31:0] len_q, len_d, lacc, len_src, len_new;
  logic [31:0] left_q, left_d, left, left_dec;
  logic [7:0]  b;
  logic        ts, step, fresh, is_len, len_done, len_zero, pay_last, eot_meta;
  logic        no_data_rs, emit, ev_end;
  logic [7:0]  one_data;
  mtep_pkg::kind_e msg_kind;

  assign step      = ~cmd_empty_i & ~res_full_i;
  assign cmd_pop_o = step;
  assign b         = cmd_i.data;
  assign ts        = cmd_i.track_start;
  assign fresh     = b[7];

  assign ph   = ts ? mtep_pkg::PH_DELTA : phase_q;
  assign dacc = ts ? '0 : delta_q;
  assign st   = ts ? '0 : status_q;
  assign cl   = ts ? mtep_pkg::CLS_UNKNOWN : cls_q;
  assign held = ts ? '0 : held_q;
  assign meta = ts ? '0 : meta_q;
  assign lacc = ts ? '0 : len_q;
  assign left = ts ? '0 : left_q;

  assign eff_st = (ph == mtep_pkg::PH_STATUS && fresh) ? b : st;
  assign eff_cl = (ph == mtep_pkg::PH_STATUS && fresh) ? cmd_i.cls : cl;

  assign len_src  = (ph == mtep_pkg::PH_STATUS) ? '0 : lacc;
  assign len_new  = {len_src[24:0], b[6:0]};
  assign is_len   = (ph == mtep_pkg::PH_LENGTH) ||
                    (ph == mtep_pkg::PH_STATUS && eff_cl == mtep_pkg::CLS_SYSEX && !fresh);
  assign len_done = is_len & ~b[7];
  assign len_zero = (len_new == '0);
  assign left_dec = (left != '0) ? left - 32'd1 : left;
  assign pay_last = (left_dec == '0);
  assign eot_meta = (eff_st == mtep_pkg::MetaStatus) && (meta == mtep_pkg::MetaEot);
  assign msg_kind = (eff_st < mtep_pkg::SysStatus) ? mtep_pkg::KIND_CHANNEL
                                                   : mtep_pkg::KIND_COMMON;
  assign one_data = (eff_st == mtep_pkg::SongSelect) ? (b & mtep_pkg::DataMask) : b;
  assign no_data_rs = (ph == mtep_pkg::PH_STATUS) && !fresh &&
                      (eff_cl == mtep_pkg::CLS_TUNE || eff_cl == mtep_pkg::CLS_UNKNOWN);

  // next phase
  always_comb begin
    phase_d = ph;
    unique case (ph)
      mtep_pkg::PH_DELTA:    phase_d = b[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
      mtep_pkg::PH_STATUS: begin
        unique case (eff_cl)
          mtep_pkg::CLS_TWO: phase_d = fresh ? mtep_pkg::PH_DATA1 : mtep_pkg::PH_DATA2;
          mtep_pkg::CLS_ONE: phase_d = fresh ? mtep_pkg::PH_DATAONE : mtep_pkg::PH_DELTA;
          mtep_pkg::CLS_SYSEX: begin
            if (fresh) begin
              phase_d = mtep_pkg::PH_LENGTH;
            end else begin
              phase_d = len_zero ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
            end
          end
          mtep_pkg::CLS_META: phase_d = fresh ? mtep_pkg::PH_METATYPE : mtep_pkg::PH_LENGTH;
          default:            phase_d = fresh ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
        endcase
      end
      mtep_pkg::PH_DATA1:    phase_d = mtep_pkg::PH_DATA2;
      mtep_pkg::PH_DATA2:    phase_d = mtep_pkg::PH_DELTA;
      mtep_pkg::PH_DATAONE:  phase_d = mtep_pkg::PH_DELTA;
      mtep_pkg::PH_METATYPE: phase_d = mtep_pkg::PH_LENGTH;
      mtep_pkg::PH_LENGTH: begin
        if (b[7]) begin
          phase_d = mtep_pkg::PH_LENGTH;
        end else begin
          phase_d = len_zero ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
        end
      end
      mtep_pkg::PH_PAYLOAD:  phase_d = pay_last ? mtep_pkg::PH_DELTA : mtep_pkg::PH_PAYLOAD;
      default:               phase_d = mtep_pkg::PH_DELTA;
    endcase
  end

  // result item
  always_comb begin
    emit                 = 1'b0;
    res_o.kind           = mtep_pkg::KIND_CHANNEL;
    res_o.delta_time     = dacc;
    res_o.status_byte    = eff_st;
    res_o.first_data     = '0;
    res_o.second_data    = '0;
    res_o.meta_type      = (eff_st == mtep_pkg::MetaStatus) ? meta : '0;
    res_o.payload_length = '0;
    res_o.payload_byte   = '0;
    res_o.last_of_event  = 1'b1;
    res_o.end_of_track   = 1'b0;
    unique case (ph)
      mtep_pkg::PH_STATUS: begin
        unique case (eff_cl)
          mtep_pkg::CLS_ONE: begin
            emit             = ~fresh;
            res_o.kind       = msg_kind;
            res_o.first_data = one_data;
          end
          mtep_pkg::CLS_SYSEX: begin
            emit                 = ~fresh & len_zero;
            res_o.kind           = mtep_pkg::KIND_EMPTY;
            res_o.payload_length = len_new;
          end
          mtep_pkg::CLS_TUNE: begin
            emit       = 1'b1;
            res_o.kind = mtep_pkg::KIND_COMMON;
          end
          mtep_pkg::CLS_UNKNOWN: begin
            emit       = 1'b1;
            res_o.kind = mtep_pkg::KIND_UNKNOWN;
          end
          default: emit = 1'b0;
        endcase
      end
      mtep_pkg::PH_DATA2: begin
        emit              = 1'b1;
        res_o.kind        = msg_kind;
        res_o.first_data  = held;
        res_o.second_data = b;
      end
      mtep_pkg::PH_DATAONE: begin
        emit             = 1'b1;
        res_o.kind       = msg_kind;
        res_o.first_data = one_data;
      end
      mtep_pkg::PH_LENGTH: begin
        emit                 = len_done & len_zero;
        res_o.kind           = mtep_pkg::KIND_EMPTY;
        res_o.payload_length = len_new;
        res_o.end_of_track   = eot_meta;
      end
      mtep_pkg::PH_PAYLOAD: begin
        emit                 = 1'b1;
        res_o.kind           = (eff_st == mtep_pkg::SysexStart) ? mtep_pkg::KIND_SYSEX :
                               (eff_st == mtep_pkg::SysexEsc)   ? mtep_pkg::KIND_ESC_SYSEX :
                                                                  mtep_pkg::KIND_META;
        res_o.payload_length = lacc;
        res_o.payload_byte   = b;
        res_o.last_of_event  = pay_last;
        res_o.end_of_track   = pay_last & eot_meta;
      end
      default: emit = 1'b0;
    endcase
    ev_end     = emit & res_o.last_of_event;
    res_push_o = step & emit;
  end

  // datapath registers
  always_comb begin
    status_d = eff_st;
    cls_d    = eff_cl;
    held_d   = held;
    meta_d   = meta;
    len_d    = lacc;
    left_d   = left;
    priority if (no_data_rs) begin
      delta_d = {25'd0, b[6:0]};
    end else if (ev_end) begin
      delta_d = '0;
    end else if (ph == mtep_pkg::PH_DELTA) begin
      delta_d = {dacc[24:0], b[6:0]};
    end else begin
      delta_d = dacc;
    end
    if (ph == mtep_pkg::PH_DATA1 ||
        (ph == mtep_pkg::PH_STATUS && eff_cl == mtep_pkg::CLS_TWO && !fresh)) begin
      held_d = b;
    end
    if (ph == mtep_pkg::PH_METATYPE ||
        (ph == mtep_pkg::PH_STATUS && eff_cl == mtep_pkg::CLS_META && !fresh)) begin
      meta_d = b;
      len_d  = '0;
    end
    if (ph == mtep_pkg::PH_STATUS && eff_cl == mtep_pkg::CLS_SYSEX && fresh) begin
      len_d = '0;
    end
    if (is_len) begin
      len_d = len_new;
    end
    if (len_done) begin
      left_d = len_new;
    end else if (ph == mtep_pkg::PH_PAYLOAD) begin
      left_d = left_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mtep_pkg::PH_DELTA;
      cls_q    <= mtep_pkg::CLS_UNKNOWN;
      delta_q  <= '0;
      status_q <= '0;
      held_q   <= '0;
      meta_q   <= '0;
      len_q    <= '0;
      left_q   <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      cls_q    <= cls_d;
      delta_q  <= delta_d;
      status_q <= status_d;
      held_q   <= held_d;
      meta_q   <= meta_d;
      len_q    <= len_d;
      left_q   <= left_d;
    end
  end

endmodule

// ===== rtl/midi_track_event_parser.sv =====
// Top level of the MIDI track event parser: front, command queue, back, result queue.
// Depends on mtep_pkg, mtep_front, mtep_fifo and mtep_back.
//
//   channel  | ports                         | transfer when
//   ---------+-------------------------------+------------------------
//   bytes in | push, full, in_item_i         | push && !full
//   results  | pop, empty, out_item_o        | pop && !empty
//
// One byte per cycle sustained while the result queue has room; the parse
// state machine in the back end handles one queued byte each cycle unless the
// result queue is full, and yields at most one result. A result enters the result
// queue as the back end takes the byte that completes it, and can then be popped.
// Reset clears both queues and the parse state; stalls on either side are
// absorbed by the queues and only reach the other side once a queue fills.
module midi_track_event_parser #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mtep_pkg::in_item_t  in_item_i,
  input  logic                pop,
  output logic                empty,
  output mtep_pkg::out_item_t out_item_o
);

  logic                cmd_valid, cmd_full, cmd_empty, cmd_pop;
  mtep_pkg::cmd_t      cmd_in, cmd_out;
  logic                res_push, res_full;
  mtep_pkg::out_item_t res_item;

  mtep_front u_front (
    .valid_i     (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  mtep_fifo #(
    .Depth  (CmdDepth),
    .item_t (mtep_pkg::cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .item_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .item_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  mtep_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  mtep_fifo #(
    .Depth  (ResDepth),
    .item_t (mtep_pkg::out_item_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (out_item_o),
    .empty_o (empty)
  );

endmodule
